@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define CSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/csa_pkg.sv @@
// types, codes and defaults for the chunked stack allocator
`default_nettype none

package csa_pkg;

  localparam int unsigned DefMaxChunks      = 16;
  localparam int unsigned DefHeaderBytes    = 12;
  localparam int unsigned DefRecordsPerChunk = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ChunkW  = 4;
  localparam int unsigned AmountW = 24;
  localparam int unsigned ByteW   = 25;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_PULL   = 2'd2
  } csa_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_POOL_FULL = 3'd2,
    ST_BAD_CHUNK = 3'd3,
    ST_CHUNK_FULL = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_MISMATCH  = 3'd6,
    ST_REC_FULL  = 3'd7
  } csa_status_e;

  // one chunk table entry
  typedef struct packed {
    logic [ByteW-1:0] base;
    logic [ByteW-1:0] limit;
    logic [ByteW-1:0] top;
  } csa_ent_t;

  // one result, ok in the lowest bit
  typedef struct packed {
    logic [ByteW-1:0]  used;
    logic [ByteW-1:0]  addr;
    logic [ChunkW-1:0] chunk;
    csa_status_e       status;
    logic              ok;
  } csa_res_t;

  // state update strobes from the evaluation logic
  typedef struct packed {
    logic emit;
    logic ent_we;
    logic pool_we;
    logic rec_we;
  } csa_upd_t;

endpackage

`default_nettype wire

@@ rtl/csa_eval.sv @@
// request evaluation: status, result and state update for one request
`default_nettype none

module csa_eval
  import csa_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS        = DefMaxChunks,
  parameter int unsigned HEADER_BYTES      = DefHeaderBytes,
  parameter int unsigned RECORDS_PER_CHUNK = DefRecordsPerChunk,
  localparam int unsigned KW  = $clog2(MAX_CHUNKS + 1),
  localparam int unsigned CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
  localparam int unsigned RCW = $clog2(RECORDS_PER_CHUNK + 1),
  localparam int unsigned RIW = (RECORDS_PER_CHUNK > 1) ? $clog2(RECORDS_PER_CHUNK) : 1
) (
  input  logic [OpW-1:0]     op_i,
  input  logic [ChunkW-1:0]  chunk_i,
  input  logic [AmountW-1:0] amount_i,
  input  logic [ByteW-1:0]   pool_bytes_i,
  input  logic [ByteW-1:0]   pool_used_i,
  input  logic [KW-1:0]      chunk_count_i,
  input  csa_ent_t           ent_i,
  input  logic [RCW-1:0]     rec_cnt_i,
  input  logic [AmountW-1:0] rec_size_i,
  output csa_res_t           res_o,
  output csa_upd_t           upd_o,
  output csa_ent_t           upd_ent_o,
  output logic [RCW-1:0]     upd_cnt_o,
  output logic [CIW-1:0]     upd_idx_o,
  output logic [ByteW-1:0]   pool_used_o,
  output logic [RIW-1:0]     rec_idx_o
);

  logic [ByteW-1:0] need;
  logic [ByteW:0]   top_sum;
  logic [ByteW:0]   pool_sum;
  logic [ByteW-1:0] top_dn;
  logic             chunk_ok;

  assign need     = ByteW'(amount_i) + ByteW'(HEADER_BYTES);
  assign top_sum  = (ByteW+1)'(ent_i.top) + (ByteW+1)'(need);
  assign pool_sum = (ByteW+1)'(pool_used_i) + (ByteW+1)'(amount_i);
  assign top_dn   = ent_i.top - need;
  assign chunk_ok = 8'(chunk_i) < 8'(chunk_count_i);

  always_comb begin
    res_o       = '0;
    res_o.status = ST_OK;
    upd_o       = '0;
    upd_ent_o   = ent_i;
    upd_cnt_o   = rec_cnt_i;
    upd_idx_o   = CIW'(chunk_i);
    pool_used_o = pool_used_i;
    rec_idx_o   = RIW'(rec_cnt_i);
    case (op_i)
      OP_CREATE: begin
        upd_o.emit = 1'b1;
        if (8'(chunk_count_i) >= 8'(MAX_CHUNKS)) begin
          res_o.status = ST_NO_SLOT;
        end else if (pool_sum > (ByteW+1)'(pool_bytes_i)) begin
          res_o.status = ST_POOL_FULL;
        end else begin
          res_o.ok      = 1'b1;
          res_o.chunk   = ChunkW'(chunk_count_i);
          res_o.addr    = pool_used_i;
          upd_o.ent_we  = 1'b1;
          upd_o.pool_we = 1'b1;
          upd_idx_o     = CIW'(chunk_count_i);
          upd_ent_o.base  = pool_used_i;
          upd_ent_o.limit = ByteW'(amount_i);
          upd_ent_o.top   = '0;
          upd_cnt_o     = '0;
          pool_used_o   = ByteW'(pool_sum);
        end
      end
      OP_PUSH: begin
        upd_o.emit  = 1'b1;
        res_o.chunk = chunk_i;
        if (!chunk_ok) begin
          res_o.status = ST_BAD_CHUNK;
        end else begin
          res_o.used = ent_i.top;
          if (top_sum > (ByteW+1)'(ent_i.limit)) begin
            res_o.status = ST_CHUNK_FULL;
          end else if (9'(rec_cnt_i) >= 9'(RECORDS_PER_CHUNK)) begin
            res_o.status = ST_REC_FULL;
          end else begin
            res_o.ok      = 1'b1;
            res_o.addr    = ent_i.base + ent_i.top;
            res_o.used    = ByteW'(top_sum);
            upd_o.ent_we  = 1'b1;
            upd_o.rec_we  = 1'b1;
            upd_ent_o.top = ByteW'(top_sum);
            upd_cnt_o     = rec_cnt_i + 1'b1;
          end
        end
      end
      OP_PULL: begin
        upd_o.emit  = 1'b1;
        res_o.chunk = chunk_i;
        if (!chunk_ok) begin
          res_o.status = ST_BAD_CHUNK;
        end else begin
          res_o.used = ent_i.top;
          if (rec_cnt_i == '0 || ent_i.top < need) begin
            res_o.status = ST_UNDERFLOW;
          end else if (rec_size_i != amount_i) begin
            res_o.status = ST_MISMATCH;
          end else begin
            res_o.ok      = 1'b1;
            res_o.addr    = ent_i.base + top_dn;
            res_o.used    = top_dn;
            upd_o.ent_we  = 1'b1;
            upd_ent_o.top = top_dn;
            upd_cnt_o     = rec_cnt_i - 1'b1;
          end
        end
      end
      default: begin
        upd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/chunked_stack_allocator_top.sv @@
// chunked stack allocator top level: request stage, tables, record store, result register
//
// channel   | dir | handshake             | payload
// s_axis    | in  | s_axis_tvalid/tready  | request: op, chunk, amount
// m_axis    | out | m_axis_tvalid/tready  | result: ok, status, chunk_out, address, used_after
// cfg       | in  | cfg_valid_i/ready_o   | pool_bytes
//
// one request per cycle unless the output stalls; results pass request and result registers
// the record store read is issued at acceptance and registered with the request stage
// chunk table and record store updates are forwarded to the request behind
// reset clears control state only; no clearing pass, requests taken right away
// a stalled result holds its request stage and, through it, the input side
module chunked_stack_allocator_top
  import csa_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS        = DefMaxChunks,
  parameter int unsigned HEADER_BYTES      = DefHeaderBytes,
  parameter int unsigned RECORDS_PER_CHUNK = DefRecordsPerChunk
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // op[1:0], chunk[5:2], amount[29:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // ok[0], status[3:1], chunk_out[7:4],
                                     // address[32:8], used_after[57:33]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [24:0] cfg_data_i
);

  localparam int unsigned KW    = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned RCW   = $clog2(RECORDS_PER_CHUNK + 1);
  localparam int unsigned RIW   = (RECORDS_PER_CHUNK > 1) ? $clog2(RECORDS_PER_CHUNK) : 1;
  localparam int unsigned DEPTH = MAX_CHUNKS * RECORDS_PER_CHUNK;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration and pool state
  logic [ByteW-1:0] pool_bytes_q;
  logic [ByteW-1:0] pool_used_q;
  logic [KW-1:0]    chunk_count_q;

  // chunk tables
  csa_ent_t       ent_q [MAX_CHUNKS];
  logic [RCW-1:0] cnt_q [MAX_CHUNKS];

  // record store
  logic [AmountW-1:0] rec_mem [DEPTH];
  logic [AmountW-1:0] rec_rd_q;
  logic               fwd_q;
  logic [AmountW-1:0] fwd_data_q;

  // request stage
  logic               a_v_q;
  logic [OpW-1:0]     a_op_q;
  logic [ChunkW-1:0]  a_chunk_q;
  logic [AmountW-1:0] a_amt_q;
  csa_ent_t           a_ent_q;
  logic [RCW-1:0]     a_cnt_q;

  // result register
  logic     o_v_q;
  csa_res_t o_res_q;

  // evaluation outputs
  csa_res_t         res;
  csa_upd_t         upd;
  csa_ent_t         upd_ent;
  logic [RCW-1:0]   upd_cnt;
  logic [CIW-1:0]   upd_idx;
  logic [ByteW-1:0] pool_used_nx;
  logic [RIW-1:0]   rec_idx;
  logic [AmountW-1:0] rec_size;

  logic           adv;
  logic           acc;
  logic           ent_wr;
  logic           rec_wr;
  logic [CIW-1:0] in_ci;
  logic           in_fwd;
  csa_ent_t       in_ent;
  logic [RCW-1:0] in_cnt;
  logic [RIW-1:0] in_ridx;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;

  assign rec_size = fwd_q ? fwd_data_q : rec_rd_q;

  csa_eval #(
    .MAX_CHUNKS        (MAX_CHUNKS),
    .HEADER_BYTES      (HEADER_BYTES),
    .RECORDS_PER_CHUNK (RECORDS_PER_CHUNK)
  ) u_eval (
    .op_i          (a_op_q),
    .chunk_i       (a_chunk_q),
    .amount_i      (a_amt_q),
    .pool_bytes_i  (pool_bytes_q),
    .pool_used_i   (pool_used_q),
    .chunk_count_i (chunk_count_q),
    .ent_i         (a_ent_q),
    .rec_cnt_i     (a_cnt_q),
    .rec_size_i    (rec_size),
    .res_o         (res),
    .upd_o         (upd),
    .upd_ent_o     (upd_ent),
    .upd_cnt_o     (upd_cnt),
    .upd_idx_o     (upd_idx),
    .pool_used_o   (pool_used_nx),
    .rec_idx_o     (rec_idx)
  );

  // handshakes
  assign adv           = a_v_q && (!upd.emit || !o_v_q || m_axis_tready);
  assign s_axis_tready = !a_v_q || adv;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign ent_wr        = adv && upd.ent_we;
  assign rec_wr        = adv && upd.rec_we;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {6'b0, o_res_q};

  // entry lookup for the incoming request, with forwarding from the stage ahead
  assign in_ci   = CIW'(s_axis_tdata[5:2]);
  assign in_fwd  = ent_wr && (upd_idx == in_ci);
  assign in_ent  = in_fwd ? upd_ent : ent_q[in_ci];
  assign in_cnt  = in_fwd ? upd_cnt : cnt_q[in_ci];
  assign in_ridx = RIW'(in_cnt - 1'b1);
  assign raddr   = AW'(16'(in_ci) * 16'(RECORDS_PER_CHUNK) + 16'(in_ridx));
  assign waddr   = AW'(16'(upd_idx) * 16'(RECORDS_PER_CHUNK) + 16'(rec_idx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_bytes_q  <= '0;
      pool_used_q   <= '0;
      chunk_count_q <= '0;
      a_v_q         <= 1'b0;
      o_v_q         <= 1'b0;
      fwd_q         <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pool_bytes_q <= cfg_data_i;
      end
      if (adv && upd.pool_we) begin
        pool_used_q   <= pool_used_nx;
        chunk_count_q <= chunk_count_q + 1'b1;
      end
      if (acc) begin
        a_v_q <= 1'b1;
        fwd_q <= rec_wr && (waddr == raddr);
      end else if (adv) begin
        a_v_q <= 1'b0;
      end
      if (adv && upd.emit) begin
        o_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_op_q     <= s_axis_tdata[1:0];
      a_chunk_q  <= s_axis_tdata[5:2];
      a_amt_q    <= s_axis_tdata[29:6];
      a_ent_q    <= in_ent;
      a_cnt_q    <= in_cnt;
      fwd_data_q <= a_amt_q;
    end
    if (adv && upd.emit) begin
      o_res_q <= res;
    end
    if (ent_wr) begin
      ent_q[upd_idx] <= upd_ent;
      cnt_q[upd_idx] <= upd_cnt;
    end
  end

  // record store, registered read at acceptance
  always_ff @(posedge clk_i) begin
    if (rec_wr) begin
      rec_mem[waddr] <= a_amt_q;
    end
    if (acc) begin
      rec_rd_q <= rec_mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/csa_checker.sv @@
// port-level checker for the chunked stack allocator, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module csa_checker
  import csa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic        res_ok;
  logic [2:0]  st;
  logic [24:0] res_addr;
  logic [24:0] res_used;
  assign res_ok   = m_axis_tdata[0];
  assign st       = m_axis_tdata[3:1];
  assign res_addr = m_axis_tdata[32:8];
  assign res_used = m_axis_tdata[57:33];

  `CSA_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

  `CSA_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  `CSA_ASSERT(a_ok_status, m_axis_tvalid |-> (res_ok == (st == ST_OK)), "ok flag disagrees with status")

  `CSA_ASSERT(a_fail_addr, m_axis_tvalid && !res_ok |-> res_addr == 25'd0, "failed request carries an address")

  `CSA_ASSERT(a_fail_used, m_axis_tvalid && (st == ST_NO_SLOT || st == ST_POOL_FULL || st == ST_BAD_CHUNK) |-> res_used == 25'd0, "failed lookup reports bytes used")

endmodule

bind chunked_stack_allocator_top csa_checker u_csa_checker (.*);

`default_nettype wire
